[sv/pnb_pkg.sv]
// Shared types for the peak normalisation block: controller states, commands and status.
`default_nettype none

package pnb_pkg;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_COLLECT = 5'b00001,
    S_READ    = 5'b00010,
    S_LOAD    = 5'b00100,
    S_DIV     = 5'b01000,
    S_OUT     = 5'b10000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // take the input request, into the buffer if there is room
    logic rd_en;    // read the buffer entry at the result index
    logic load;     // load the divider from the read data
    logic step;     // run one restoring division step
    logic advance;  // result taken: move to the next entry or close the block
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;   // the current step is the last of the division
    logic last_item;  // the result index points at the last buffered sample
  } stat_t;

endpackage

`default_nettype wire

[sv/pnb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pnb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/pnb_ctrl.sv]
// Controller state machine for the peak normalisation block.
`default_nettype none

module pnb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_final_sample,
  input  wire logic           out_ready,
  input  wire pnb_pkg::stat_t stat,
  output logic                in_ready,
  output logic                out_valid,
  output pnb_pkg::cmd_t       cmd
);

  pnb_pkg::state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      pnb_pkg::S_COLLECT: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_final_sample) begin
          state_nxt = pnb_pkg::S_READ;
        end
      end
      pnb_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = pnb_pkg::S_LOAD;
      end
      pnb_pkg::S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = pnb_pkg::S_DIV;
      end
      pnb_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_nxt = pnb_pkg::S_OUT;
        end
      end
      pnb_pkg::S_OUT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
        if (out_ready) begin
          state_nxt = stat.last_item ? pnb_pkg::S_COLLECT : pnb_pkg::S_READ;
        end
      end
      default: begin
        state_nxt = pnb_pkg::S_COLLECT;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pnb_pkg::S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The two channels never open at once
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels open together");

  // A buffer read is always followed by a divider load
  a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> cmd.load)
    else $error("buffer read not followed by divider load");

  // A final request always starts the read-out
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_final_sample) |=> cmd.rd_en)
    else $error("final request did not start read-out");

endmodule

`default_nettype wire

[sv/pnb_dp.sv]
// Datapath: sample buffer, peak tracking, restoring divider and result fields.
`default_nettype none

module pnb_dp #(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pnb_pkg::cmd_t          cmd,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output pnb_pkg::stat_t              stat,
  output logic [SAMPLE_BITS:0]        out_scaled_value,
  output logic                        out_final_result,
  output logic                        out_truncated
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int SW = $clog2(SAMPLE_BITS + 1);

  logic [CW-1:0]          count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [SW-1:0]          step_r, step_nxt;
  logic [SAMPLE_BITS:0]   rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;
  logic                   neg_r, neg_nxt;

  logic                   room;
  logic                   wr_en;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] rd_mag;
  logic [SAMPLE_BITS:0]   peak_ext;
  logic                   ge;
  logic [SAMPLE_BITS:0]   part;
  logic [SAMPLE_BITS:0]   quo_ext;

  // Buffer for the raw samples of one block
  pnb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_sample),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Magnitudes of the incoming and read-back samples
  assign room   = count_r < CW'(MAX_SAMPLES);
  assign wr_en  = cmd.accept && room;
  assign in_mag = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
  assign rd_mag = rd_data[SAMPLE_BITS-1] ? (~rd_data + 1'b1) : rd_data;

  // One restoring division step
  assign peak_ext = {1'b0, peak_r};
  assign ge       = rem_r >= peak_ext;
  assign part     = ge ? (rem_r - peak_ext) : rem_r;

  assign stat.div_last  = step_r == SW'(1);
  assign stat.last_item = (CW'(idx_r) + CW'(1)) == count_r;

  // Update block and divider state
  always_comb begin
    count_nxt = count_r;
    peak_nxt  = peak_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    neg_nxt   = neg_r;
    if (cmd.accept) begin
      if (room) begin
        count_nxt = count_r + CW'(1);
        if (in_mag > peak_r) begin
          peak_nxt = in_mag;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.load) begin
      rem_nxt  = {1'b0, rd_mag};
      neg_nxt  = rd_data[SAMPLE_BITS-1];
      quo_nxt  = '0;
      step_nxt = SW'(SAMPLE_BITS);
    end
    if (cmd.step) begin
      rem_nxt  = {part[SAMPLE_BITS-1:0], 1'b0};
      quo_nxt  = {quo_r[SAMPLE_BITS-2:0], ge};
      step_nxt = step_r - SW'(1);
    end
    if (cmd.advance) begin
      if (stat.last_item) begin
        count_nxt = '0;
        peak_nxt  = '0;
        ovf_nxt   = 1'b0;
        idx_nxt   = '0;
      end else begin
        idx_nxt = idx_r + AW'(1);
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      peak_r  <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

  // Hold divider payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  // Apply sign; a zero peak means every sample is zero
  assign quo_ext          = {1'b0, quo_r};
  assign out_scaled_value = (peak_r == '0) ? '0 : (neg_r ? (~quo_ext + 1'b1) : quo_ext);
  assign out_final_result = stat.last_item;
  assign out_truncated    = ovf_r;

  // Buffer fill never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("buffer fill beyond depth");

  // A loaded magnitude never exceeds the block peak
  a_mag_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> rem_r <= {1'b0, peak_r})
    else $error("sample magnitude above block peak");

  // Closing a block clears its state
  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && stat.last_item) |=> (count_r == '0 && peak_r == '0 && !ovf_r))
    else $error("block state not cleared");

endmodule

`default_nettype wire

[sv/peak_normalise_block.sv]
// Peak normalise block: buffers a block of samples and emits each divided by the block peak.
//
// Input channel (in_valid/in_ready): one signed Q1.F sample per request, in_final_sample
// set on the last one. While collecting, in_ready is high and each request is taken when
// offered; up to MAX_SAMPLES are buffered and further ones are dropped (out_truncated is
// then set on every result of that block). A final request always ends the block.
// Result channel (out_valid/out_ready): one Q2.F result per buffered sample, in arrival
// order, out_final_result on the last. No input is taken while a block is being read out.
// Each result is worked out by one buffer read, one divider load and SAMPLE_BITS
// restoring division steps, then waits in the output until taken; the next buffer read
// starts only once it is taken, so one result is worked on at a time. The radix-2
// divider produces one quotient bit a cycle.
// When the receiver stalls, the result and all state hold until it is taken.
// Reset clears the buffer fill, peak and drop flag and returns to collecting; buffer
// contents are not cleared and need no clearing pass.
`default_nettype none

module peak_normalise_block #(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_final_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SAMPLE_BITS:0]        out_scaled_value,
  output logic                        out_final_result,
  output logic                        out_truncated
);

  pnb_pkg::cmd_t  cmd;
  pnb_pkg::stat_t stat;

  // Sequencing of collection and read-out
  pnb_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_final_sample (in_final_sample),
    .out_ready       (out_ready),
    .stat            (stat),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .cmd             (cmd)
  );

  // Buffer, peak and divider
  pnb_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_sample        (in_sample),
    .stat             (stat),
    .out_scaled_value (out_scaled_value),
    .out_final_result (out_final_result),
    .out_truncated    (out_truncated)
  );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the peak normalise block: directed table, then random blocks.
`default_nettype none

module tb_top;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int DRAIN_CYCLES = 60;

  // One result as it should leave the block
  typedef struct packed {
    logic [SAMPLE_BITS:0] value;
    logic                 last;
    logic                 dropped;
  } norm_result_t;

  // One row of the directed table; want is used only where typed is set
  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_flag;
    bit                     typed;
    logic [SAMPLE_BITS:0]   want;
  } sample_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic                   in_final_sample = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS:0]   out_scaled_value;
  logic                   out_final_result;
  logic                   out_truncated;

  // Idle percentages of sender and receiver, set per phase
  int unsigned snd_idle_pct = 21;
  int unsigned rcv_idle_pct = 79;

  // Typed expectation riding with the request on the input port
  bit                   drv_typed = 1'b0;
  logic [SAMPLE_BITS:0] drv_want = '0;

  // Block state mirrored for prediction
  logic [SAMPLE_BITS-1:0] held_raw   [MAX_SAMPLES];
  bit                     held_typed [MAX_SAMPLES];
  logic [SAMPLE_BITS:0]   held_want  [MAX_SAMPLES];
  int unsigned            held_count = 0;
  logic [SAMPLE_BITS:0]   block_peak = '0;
  logic                   block_dropped = 1'b0;

  norm_result_t pending_results[$];
  int unsigned  error_count = 0;

  peak_normalise_block #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_final_sample  (in_final_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scaled_value (out_scaled_value),
    .out_final_result (out_final_result),
    .out_truncated    (out_truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of a Q1.15 sample, 2^15 for the most negative one
  function automatic logic [SAMPLE_BITS:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
    if (raw[SAMPLE_BITS-1]) begin
      return (17'd1 << SAMPLE_BITS) - {1'b0, raw};
    end
    return {1'b0, raw};
  endfunction

  // Sample over peak in Q2.15, truncated toward zero
  function automatic logic [SAMPLE_BITS:0] normalised(input logic [SAMPLE_BITS-1:0] raw,
                                                      input logic [SAMPLE_BITS:0] peak);
    logic [31:0] num;
    logic [31:0] quot;
    if (peak == '0) begin
      return '0;
    end
    num  = 32'(magnitude(raw)) << (SAMPLE_BITS - 1);
    quot = num / 32'(peak);
    if (raw[SAMPLE_BITS-1]) begin
      quot = 32'd0 - quot;
    end
    return quot[SAMPLE_BITS:0];
  endfunction

  // Buffer an accepted request; on the final one queue the whole block's results
  task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] raw, input logic last,
                               input bit typed, input logic [SAMPLE_BITS:0] want);
    norm_result_t res;
    if (held_count < MAX_SAMPLES) begin
      held_raw[held_count]   = raw;
      held_typed[held_count] = typed;
      held_want[held_count]  = want;
      held_count++;
      if (magnitude(raw) > block_peak) begin
        block_peak = magnitude(raw);
      end
    end else begin
      block_dropped = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < held_count; k++) begin
        res.value   = held_typed[k] ? held_want[k] : normalised(held_raw[k], block_peak);
        res.last    = (k == held_count - 1);
        res.dropped = block_dropped;
        pending_results.push_back(res);
      end
      held_count    = 0;
      block_peak    = '0;
      block_dropped = 1'b0;
    end
  endtask

  // Compare a result leaving the block against the oldest expectation
  task automatic check_result();
    norm_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result: scaled_value=%h", out_scaled_value);
      error_count++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (out_scaled_value !== exp_res.value) begin
      $error("scaled_value: expected %h, got %h", exp_res.value, out_scaled_value);
      error_count++;
    end
    if (out_final_result !== exp_res.last) begin
      $error("final_result: expected %b, got %b", exp_res.last, out_final_result);
      error_count++;
    end
    if (out_truncated !== exp_res.dropped) begin
      $error("truncated: expected %b, got %b", exp_res.dropped, out_truncated);
      error_count++;
    end
  endtask

  // Sample both handshakes on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_sample(in_sample, in_final_sample, drv_typed, drv_want);
      end
      if (out_valid && out_ready) begin
        check_result();
      end
    end
  end

  // Receiver: stall at random on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Offer one request, idling first at random, and hold it until taken
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input logic last,
                             input bit typed, input logic [SAMPLE_BITS:0] want);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_final_sample <= last;
    drv_typed        = typed;
    drv_want         = want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Draw a sample in the given flavour
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int flavour);
    logic signed [SAMPLE_BITS-1:0] v;
    case (flavour)
      0: begin
        return SAMPLE_BITS'($urandom);
      end
      1: begin
        return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
      end
      2: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          3:       return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      3: begin
        v = SAMPLE_BITS'($urandom);
        return v >>> $urandom_range(1, 14);
      end
      4: begin
        return '0;
      end
      default: begin
        return pick_sample($urandom_range(0, 3));
      end
    endcase
  endfunction

  // Send one block of len requests, the last one marked
  task automatic send_block(input int len, input int flavour);
    for (int i = 0; i < len; i++) begin
      push_sample(pick_sample(flavour), (i == len - 1), 1'b0, '0);
    end
  endtask

  // Directed blocks: full scale, most negative peak, zero peak, exact and inexact ratios
  sample_row_t directed_rows[19] = '{
    '{16'h7FFF, 1'b1, 1'b1, 17'h08000},
    '{16'h8000, 1'b1, 1'b1, 17'h18000},
    '{16'h0000, 1'b0, 1'b1, 17'h00000},
    '{16'h0000, 1'b0, 1'b1, 17'h00000},
    '{16'h0000, 1'b1, 1'b1, 17'h00000},
    '{16'h4000, 1'b0, 1'b1, 17'h08000},
    '{16'hE000, 1'b0, 1'b1, 17'h1C000},
    '{16'h1000, 1'b1, 1'b1, 17'h02000},
    '{16'h8000, 1'b0, 1'b1, 17'h18000},
    '{16'h7FFF, 1'b0, 1'b1, 17'h07FFF},
    '{16'h0001, 1'b0, 1'b1, 17'h00001},
    '{16'hFFFF, 1'b1, 1'b1, 17'h1FFFF},
    '{16'h0003, 1'b0, 1'b0, 17'h00000},
    '{16'hFFF9, 1'b0, 1'b0, 17'h00000},
    '{16'h000A, 1'b1, 1'b0, 17'h00000},
    '{16'hFFFB, 1'b0, 1'b1, 17'h18000},
    '{16'h0005, 1'b1, 1'b1, 17'h08000},
    '{16'h0001, 1'b0, 1'b0, 17'h00000},
    '{16'h7FFE, 1'b1, 1'b0, 17'h00000}
  };

  initial begin
    int sent;
    int len;

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      push_sample(directed_rows[i].sample, directed_rows[i].last_flag,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Three idling phases, each with an opening block and a run of short ones;
    // the first opening block overfills the buffer
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 21;
          rcv_idle_pct = 79;
          len = MAX_SAMPLES + 1 + $urandom_range(0, 2);
        end
        1: begin
          snd_idle_pct = 79;
          rcv_idle_pct = 21;
          len = $urandom_range(2, 6);
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          len = $urandom_range(2, 6);
        end
      endcase
      send_block(len, $urandom_range(0, 5));
      sent = 0;
      while (sent < 6) begin
        len = $urandom_range(1, 4);
        send_block(len, $urandom_range(0, 5));
        sent += len;
      end
    end

    // Drop valid, drain the expected results, then allow stray ones to show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

[peak_normalise_block.f]
sv/pnb_pkg.sv
sv/pnb_ram.sv
sv/pnb_ctrl.sv
sv/pnb_dp.sv
sv/peak_normalise_block.sv
sim/tb_top.sv
